/* design/ftc_pkg.sv */
package ftc_pkg;

  localparam int DVD_W  = 26;
  localparam int DVS_W  = 18;
  localparam int SIDE_W = 64;

  // ceil(2^32 / 60) and ceil(2^20 / 24)
  localparam logic [26:0] RCP60 = 27'd71582789;
  localparam logic [15:0] RCP24 = 16'd43691;

  localparam logic [1:0] CFG_FPS    = 2'd0;
  localparam logic [1:0] CFG_DROP   = 2'd1;
  localparam logic [1:0] CFG_OFFSET = 2'd2;
  localparam logic [1:0] CFG_FMODE  = 2'd3;

  localparam logic [1:0] FMODE_NONE   = 2'd0;
  localparam logic [1:0] FMODE_HIGH   = 2'd1;
  localparam logic [1:0] FMODE_50     = 2'd2;
  localparam logic [1:0] FMODE_UNUSED = 2'd3;

  // tens in [7:4], units in [3:0]; v below 100
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [3:0] tens;
    logic [7:0] units;
    tens = 4'd0;
    for (int t = 1; t < 10; t++) begin
      if (v >= 8'(10 * t)) tens = 4'(t);
    end
    units = v - 8'(tens) * 8'd10;
    return {tens, units[3:0]};
  endfunction

  function automatic logic [7:0] mod40(input logic [7:0] v);
    logic [2:0] q;
    q = 3'd0;
    for (int j = 1; j < 7; j++) begin
      if (v >= 8'(40 * j)) q = 3'(j);
    end
    return v - 8'(q) * 8'd40;
  endfunction

endpackage

/* design/frame_to_smpte_timecode_core.sv */
// Frame index to SMPTE 12M BCD timecode word.
// Input stream s_axis_*: one beat carries a 24-bit frame index.
// Output stream m_axis_*: one beat carries the 31-bit timecode word.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
// (0 rate, 1 drop-frame enable, 2 start offset, 3 field bit mode);
// write only while no beat is in flight.
// The pipeline has one input stage, three restoring dividers of
// 26 stages each (drop block, minute in block, rate), one renumber stage,
// four stages that split seconds, minutes and hours by reciprocal
// multiplication, and the output register.
// Throughput is one beat per cycle while the output beat is taken.
// The whole pipeline moves as one: when the output register holds a beat
// that is not taken, every stage holds and s_axis_tready drops.
// Reset clears all valid bits and loads the register defaults
// (30 fps, no drop frame, zero offset, field mode 0).
module frame_to_smpte_timecode_core import ftc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] frame_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] timecode_word
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [23:0] cfg_wdata_i
);

  logic [7:0]  fps_q;
  logic        drop_q;
  logic [23:0] offset_q;
  logic [1:0]  fmode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q    <= 8'd30;
      drop_q   <= 1'b0;
      offset_q <= '0;
      fmode_q  <= FMODE_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_FPS:    fps_q    <= cfg_wdata_i[7:0];
        CFG_DROP:   drop_q   <= cfg_wdata_i[0];
        CFG_OFFSET: offset_q <= cfg_wdata_i;
        CFG_FMODE:  fmode_q  <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // derived rate constants
  logic [3:0]       k_d;
  logic             mult_d;
  logic [DVS_W-1:0] block_q, permin_q, fpse_q;
  logic [4:0]       skip_q;
  logic [7:0]       c9_q;

  always_comb begin
    k_d    = 4'd0;
    mult_d = 1'b0;
    for (int j = 1; j < 9; j++) begin
      if (fps_q == 8'(30 * j)) begin
        k_d    = 4'(j);
        mult_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_q  <= DVS_W'(17982);
      permin_q <= DVS_W'(1798);
      skip_q   <= 5'd2;
      c9_q     <= 8'd18;
      fpse_q   <= DVS_W'(30);
    end else begin
      block_q  <= DVS_W'(k_d) * DVS_W'(17982);
      permin_q <= DVS_W'(k_d) * DVS_W'(1798) + DVS_W'(k_d >= 4'd5);
      skip_q   <= {k_d, 1'b0};
      c9_q     <= 8'(k_d) * 8'd18;
      fpse_q   <= (fps_q == 8'd0) ? DVS_W'(1) : DVS_W'(fps_q);
    end
  end

  logic adv;
  logic out_vld_q;
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // input stage
  logic             s0_vld_q;
  logic [DVD_W-1:0] s0_n_q;
  logic             s0_dd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_n_q  <= DVD_W'(s_axis_tdata) + DVD_W'(offset_q);
      s0_dd_q <= drop_q && mult_d;
    end
  end

  // n / block
  logic             d1_vld;
  logic [DVD_W-1:0] d1_q;
  logic [DVS_W-1:0] d1_r;
  logic [SIDE_W-1:0] d1_s;

  ftc_div u_div_block (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(s0_vld_q), .dividend_i(s0_n_q), .divisor_i(block_q),
    .side_i(SIDE_W'({s0_dd_q, s0_n_q})),
    .valid_o(d1_vld), .quot_o(d1_q), .rem_o(d1_r), .side_o(d1_s)
  );

  // (m - skip) / per_min
  logic [DVS_W-1:0] t_m;
  assign t_m = (d1_r < DVS_W'(skip_q)) ? '0 : d1_r - DVS_W'(skip_q);

  logic             d2_vld;
  logic [DVD_W-1:0] d2_q;
  logic [DVS_W-1:0] d2_r;
  logic [SIDE_W-1:0] d2_s;

  ftc_div u_div_min (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(d1_vld), .dividend_i(DVD_W'(t_m)), .divisor_i(permin_q),
    .side_i(SIDE_W'({d1_q[10:0], d1_s[DVD_W:0]})),
    .valid_o(d2_vld), .quot_o(d2_q), .rem_o(d2_r), .side_o(d2_s)
  );

  // renumber stage
  logic             rb_vld_q;
  logic [DVD_W-1:0] rb_n_q;
  logic [DVD_W-1:0] rb_n;
  logic [10:0]      rb_d;
  logic             rb_dd;

  assign rb_n  = d2_s[DVD_W-1:0];
  assign rb_dd = d2_s[DVD_W];
  assign rb_d  = d2_s[DVD_W+11:DVD_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_vld_q <= 1'b0;
    end else if (adv) begin
      rb_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rb_n_q <= rb_dd ? rb_n + DVD_W'(c9_q) * DVD_W'(rb_d)
                             + DVD_W'(skip_q) * DVD_W'(d2_q[3:0])
                      : rb_n;
    end
  end

  // n / fps
  logic             d3_vld;
  logic [DVD_W-1:0] d3_q;
  logic [DVS_W-1:0] d3_r;
  logic [SIDE_W-1:0] d3_s;

  ftc_div u_div_fps (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(rb_vld_q), .dividend_i(rb_n_q), .divisor_i(fpse_q),
    .side_i('0),
    .valid_o(d3_vld), .quot_o(d3_q), .rem_o(d3_r), .side_o(d3_s)
  );

  // total seconds / 60
  logic        t1_vld_q;
  logic [25:0] t1_s_q;
  logic [20:0] t1_m_q;
  logic [7:0]  t1_ff_q;
  logic [52:0] t1_prod;

  assign t1_prod = d3_q * RCP60;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q <= 1'b0;
    end else if (adv) begin
      t1_vld_q <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_s_q  <= d3_q;
      t1_m_q  <= t1_prod[52:32];
      t1_ff_q <= d3_r[7:0] | d3_s[7:0];
    end
  end

  // seconds; total minutes / 60
  logic        t2_vld_q;
  logic [20:0] t2_m_q;
  logic [15:0] t2_h_q;
  logic [5:0]  t2_ss_q;
  logic [7:0]  t2_ff_q;
  logic [47:0] t2_prod;

  assign t2_prod = t1_m_q * RCP60;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_vld_q <= 1'b0;
    end else if (adv) begin
      t2_vld_q <= t1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t2_m_q  <= t1_m_q;
      t2_h_q  <= t2_prod[47:32];
      t2_ss_q <= 6'(t1_s_q - 26'(t1_m_q) * 26'd60);
      t2_ff_q <= t1_ff_q;
    end
  end

  // minutes; total hours / 24
  logic        t3_vld_q;
  logic [15:0] t3_h_q;
  logic [11:0] t3_d_q;
  logic [5:0]  t3_mm_q;
  logic [5:0]  t3_ss_q;
  logic [7:0]  t3_ff_q;
  logic [31:0] t3_prod;

  assign t3_prod = t2_h_q * RCP24;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t3_vld_q <= 1'b0;
    end else if (adv) begin
      t3_vld_q <= t2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t3_h_q  <= t2_h_q;
      t3_d_q  <= t3_prod[31:20];
      t3_mm_q <= 6'(t2_m_q - 21'(t2_h_q) * 21'd60);
      t3_ss_q <= t2_ss_q;
      t3_ff_q <= t2_ff_q;
    end
  end

  // hours
  logic       t4_vld_q;
  logic [4:0] t4_hh_q;
  logic [5:0] t4_mm_q;
  logic [5:0] t4_ss_q;
  logic [7:0] t4_ff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t4_vld_q <= 1'b0;
    end else if (adv) begin
      t4_vld_q <= t3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t4_hh_q <= 5'(t3_h_q - 16'(t3_d_q) * 16'd24);
      t4_mm_q <= t3_mm_q;
      t4_ss_q <= t3_ss_q;
      t4_ff_q <= t3_ff_q;
    end
  end

  // pack
  logic [7:0]  ff_raw, ff_h, ff_m, ff_b, ss_b, mm_b, hh_b;
  logic [30:0] word;

  always_comb begin
    ff_raw = t4_ff_q;
    ff_h   = (fmode_q != FMODE_NONE) ? {1'b0, ff_raw[7:1]} : ff_raw;
    ff_m   = mod40(ff_h);
    ff_b   = to_bcd(ff_m);
    ss_b   = to_bcd({2'b00, t4_ss_q});
    mm_b   = to_bcd({2'b00, t4_mm_q});
    hh_b   = to_bcd({3'b000, t4_hh_q});
    word   = {drop_q, ff_b[5:4], ff_b[3:0], ss_b, mm_b, hh_b};
    if (fmode_q != FMODE_NONE && ff_raw[0]) begin
      if (fmode_q == FMODE_50) word[7] = 1'b1;
      else                     word[23] = 1'b1;
    end
  end

  logic [30:0] out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= t4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q <= word;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_word_q};

endmodule

/* design/ftc_div.sv */
module ftc_div import ftc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DVD_W-1:0]  quot_o,
  output logic [DVS_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [DVD_W-1:0]  dvd_q  [DVD_W];
  logic [DVS_W-1:0]  rem_q  [DVD_W];
  logic [SIDE_W-1:0] side_q [DVD_W];
  logic              vld_q  [DVD_W];

  for (genvar i = 0; i < DVD_W; i++) begin : g_stage
    logic [DVD_W-1:0]  dvd_p;
    logic [DVS_W-1:0]  rem_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign dvd_p  = dividend_i;
      assign rem_p  = '0;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign dvd_p  = dvd_q[i-1];
      assign rem_p  = rem_q[i-1];
      assign side_p = side_q[i-1];
      assign vld_p  = vld_q[i-1];
    end

    assign trial = {rem_p, dvd_p[DVD_W-1]};
    assign diff  = trial - {1'b0, divisor_i};
    assign ge    = trial >= {1'b0, divisor_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[i]  <= {dvd_p[DVD_W-2:0], ge};
        rem_q[i]  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        side_q[i] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[DVD_W-1];
  assign quot_o  = dvd_q[DVD_W-1];
  assign rem_o   = rem_q[DVD_W-1];
  assign side_o  = side_q[DVD_W-1];

endmodule
